/* rtl/lad_pkg.sv */
// shared types, constants and micro-program of the ladder low-pass filter
package lad_pkg;

  // coefficient constants, unsigned q2.30
  localparam logic [31:0] QONE  = 32'd1073741824;
  localparam logic [31:0] C_1P8 = 32'd1932735283;
  localparam logic [31:0] C_0P8 = 32'd858993459;
  localparam logic [31:0] C_T   = 32'd1488473530;

  // configuration port
  localparam int CFG_W = 18;
  localparam logic [1:0] CFG_CUTOFF = 2'd0;
  localparam logic [1:0] CFG_RESON  = 2'd1;
  localparam logic [1:0] CFG_RATE   = 2'd2;

  // shared divider geometry
  localparam int DIV_W  = 56;
  localparam int DIV_VW = 26;
  localparam int DIV_LW = 6;

  // last step of each micro-program
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] COEF_LAST = 5'd15;
  localparam logic [STEP_W-1:0] RUN_LAST  = 5'd30;

  typedef enum logic [1:0] {
    ST_COEF,
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_WAIT_DIV,
    OP_FB,
    OP_MX,
    OP_XP,
    OP_OPM,
    OP_YK,
    OP_STG,
    OP_SQ,
    OP_CU,
    OP_DIV_CU,
    OP_CLIP,
    OP_FIN,
    OP_DIV_F,
    OP_SET_F,
    OP_C1,
    OP_SET_U,
    OP_C2,
    OP_SET_P,
    OP_C3,
    OP_SET_T,
    OP_C4,
    OP_SET_N,
    OP_DIV_S,
    OP_SET_S,
    OP_C5,
    OP_SET_R
  } op_t;

  typedef enum logic [1:0] {
    SH_30,
    SH_X,
    SH_16
  } sh_t;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_LOAD,
    TAG_ADD,
    TAG_SUB,
    TAG_XSUB
  } tag_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] stage;
    logic       take;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] stage;
  } prog_t;

  // micro-program word for a given sequence and step
  function automatic prog_t prog_word(input state_t st, input logic [STEP_W-1:0] step);
    prog_t w;
    logic [STEP_W-1:0] k;
    logic [STEP_W-1:0] sub;
    w.op = OP_NOP;
    w.stage = 2'd0;
    k = step - 5'd3;
    sub = k;
    if (st == ST_COEF) begin
      case (step)
        5'd0:  w.op = OP_DIV_F;
        5'd1:  w.op = OP_WAIT_DIV;
        5'd2:  w.op = OP_SET_F;
        5'd3:  w.op = OP_C1;
        5'd4:  w.op = OP_SET_U;
        5'd5:  w.op = OP_C2;
        5'd6:  w.op = OP_SET_P;
        5'd7:  w.op = OP_C3;
        5'd8:  w.op = OP_SET_T;
        5'd9:  w.op = OP_C4;
        5'd10: w.op = OP_SET_N;
        5'd11: w.op = OP_DIV_S;
        5'd12: w.op = OP_WAIT_DIV;
        5'd13: w.op = OP_SET_S;
        5'd14: w.op = OP_C5;
        5'd15: w.op = OP_SET_R;
        default: w.op = OP_NOP;
      endcase
    end else if (step >= 5'd3 && step <= 5'd22) begin
      // four ladder stages, five steps each
      if (k < 5'd5) begin
        w.stage = 2'd0;
        sub = k;
      end else if (k < 5'd10) begin
        w.stage = 2'd1;
        sub = k - 5'd5;
      end else if (k < 5'd15) begin
        w.stage = 2'd2;
        sub = k - 5'd10;
      end else begin
        w.stage = 2'd3;
        sub = k - 5'd15;
      end
      case (sub)
        5'd0: w.op = OP_XP;
        5'd1: w.op = OP_OPM;
        5'd2: w.op = OP_YK;
        5'd4: w.op = OP_STG;
        default: w.op = OP_NOP;
      endcase
    end else begin
      case (step)
        5'd0:  w.op = OP_FB;
        5'd2:  w.op = OP_MX;
        5'd23: w.op = OP_SQ;
        5'd25: w.op = OP_CU;
        5'd27: w.op = OP_DIV_CU;
        5'd28: w.op = OP_WAIT_DIV;
        5'd29: w.op = OP_CLIP;
        5'd30: w.op = OP_FIN;
        default: w.op = OP_NOP;
      endcase
    end
    return w;
  endfunction

endpackage

/* rtl/lad_div.sv */
// restoring divider, one quotient bit per cycle
module lad_div #(
  parameter int DW = 56,
  parameter int VW = 26,
  parameter int LW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [LW-1:0] len,
  output logic          done,
  output logic [DW-1:0] quot
);

  logic          busy_r;
  logic          done_r;
  logic [LW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dsr_r;
  logic [VW:0]   rem_sh;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  // shift in next dividend bit and try subtract
  always_comb begin
    rem_sh = {rem_r, dvd_r[DW-1]};
    ge = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? VW'(rem_sh - {1'b0, dsr_r}) : rem_sh[VW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == LW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

/* rtl/lad_dp.sv */
// datapath: state, coefficients, shared multiplier and divider
module lad_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lad_pkg::cmd_t                         cmd,
  output lad_pkg::stat_t                        stat,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample_out,
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_index,
  input  logic [lad_pkg::CFG_W-1:0]             cfg_wdata
);
  import lad_pkg::*;

  localparam int XFRAC = STATE_WIDTH - 5;
  localparam int SFRAC = SAMPLE_WIDTH - 1;
  localparam int MW = (STATE_WIDTH + 4 > 34) ? STATE_WIDTH + 4 : 34;
  localparam int PW = 2 * MW;
  localparam int AW = STATE_WIDTH + 16;
  localparam int XSH_L = (XFRAC >= SFRAC) ? XFRAC - SFRAC : 0;
  localparam int XSH_R = (XFRAC >= SFRAC) ? 0 : SFRAC - XFRAC;
  localparam int CU_W = STATE_WIDTH + 8;
  localparam int CU_LB = CU_W - 20;
  localparam int DA_K = 23;
  localparam logic [20:0] DA_M = 21'd1398102;
  localparam int DB_K = CU_LB + 5;
  localparam logic [CU_LB+2:0] DB_M = (CU_LB+3)'(((longint'(1) << DB_K) + 5) / 6);
  localparam logic [DIV_LW-1:0] LEN_F = 6'd49;
  localparam logic [DIV_LW-1:0] LEN_S = 6'd56;
  localparam logic signed [AW-1:0] ST_MAX =
    {{(AW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [AW-1:0] SMP_MAX =
    {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] SMP_MIN = ~SMP_MAX;

  function automatic logic signed [STATE_WIDTH-1:0] sat_st(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] c;
    c = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
    return c[STATE_WIDTH-1:0];
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] a;
    a = v[AW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  // configuration registers
  logic [17:0] cut_r;
  logic [16:0] res_r;
  logic [17:0] rate_r;

  // filter state
  logic signed [STATE_WIDTH-1:0] so_r [4];
  logic signed [STATE_WIDTH-1:0] pi_r [4];
  logic signed [STATE_WIDTH-1:0] cur_r;
  logic signed [SAMPLE_WIDTH-1:0] samp_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_r;
  logic out_valid_r;

  // coefficients and temporaries
  logic [30:0] f_r;
  logic [31:0] u_r;
  logic [30:0] p_r;
  logic signed [31:0] k_r;
  logic [31:0] r_r;
  logic [31:0] t_r;
  logic [35:0] num_r;
  logic [35:0] den_r;
  logic [33:0] scale_r;

  // multiplier stage
  logic [PW-1:0] prod_r;
  logic neg_r;
  sh_t sh_r;
  tag_t tag_r;
  logic [MW-1:0] a_m;
  logic [MW-1:0] b_m;
  logic neg_c;
  sh_t sh_c;
  tag_t tag_c;
  logic mul_en;
  logic [PW-1:0] psh;
  logic signed [AW-1:0] pmag;
  logic signed [AW-1:0] pval;

  // divider hookup
  logic div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DIV_VW-1:0] div_dsr;
  logic [DIV_LW-1:0] div_len;
  logic div_done;
  logic [DIV_W-1:0] quot;

  // cube divided by six, upper and lower chunk
  logic [CU_W-1:0] cu_n;
  logic [19:0] cu_hi_r;
  logic [CU_LB-1:0] cu_lo_r;
  logic [19:0] qa_r;
  logic [19:0] qa_nxt;
  logic [40:0] qa_prod;
  logic [2:0] ra;
  logic [CU_LB+2:0] low_r;
  logic [CU_LB+2:0] low_nxt;
  logic [2*CU_LB+5:0] ql_prod;
  logic [CU_LB-1:0] ql_r;
  logic [CU_LB-1:0] ql_nxt;
  logic [CU_W-1:0] cu_q;
  logic d1_r;
  logic d2_r;
  logic d3_r;

  // misc combinational
  logic signed [AW-1:0] xs;
  logic signed [AW-1:0] xconv;
  logic signed [AW-1:0] acc_abs;
  logic signed [AW-1:0] qv;
  logic signed [AW-1:0] qs;
  logic signed [STATE_WIDTH-1:0] y_sat;
  logic signed [AW-1:0] yo;
  logic signed [AW-1:0] ow;
  logic signed [AW-1:0] ow_sat;
  logic [16:0] res_sat;
  logic [35:0] t2;
  logic [35:0] six_t;
  logic f_full;
  logic out_take;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r <= 18'd48000;
      res_r <= 17'd0;
      rate_r <= 18'd48000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CUTOFF: cut_r <= cfg_wdata;
        CFG_RESON:  res_r <= cfg_wdata[16:0];
        CFG_RATE:   rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample format conversions and clip helpers
  always_comb begin
    xs = AW'(samp_r);
    xconv = (xs <<< XSH_L) >>> XSH_R;
    acc_abs = acc_r[AW-1] ? -acc_r : acc_r;
    qv = AW'(cu_q);
    qs = acc_r[AW-1] ? -qv : qv;
    y_sat = sat_st(acc_r);
    yo = AW'(y_sat);
    ow = (yo <<< XSH_R) >>> XSH_L;
    ow_sat = (ow > SMP_MAX) ? SMP_MAX : ((ow < SMP_MIN) ? SMP_MIN : ow);
    res_sat = (res_r > 17'd65536) ? 17'd65536 : res_r;
    t2 = 36'(12) * 36'(QONE) + 36'(psh[31:0]);
    six_t = 36'({t_r, 2'b00}) + 36'({t_r, 1'b0});
    f_full = (rate_r == 18'd0) || ({cut_r, 1'b0} >= {1'b0, rate_r});
    out_take = out_valid_r && !out_stall;
  end

  // multiplier operand selection
  always_comb begin
    a_m = '0;
    b_m = '0;
    neg_c = 1'b0;
    sh_c = SH_30;
    tag_c = TAG_NONE;
    mul_en = 1'b1;
    case (cmd.op)
      OP_FB: begin
        a_m = mag(AW'(so_r[3]));
        b_m = MW'(r_r);
        neg_c = so_r[3][STATE_WIDTH-1];
        tag_c = TAG_XSUB;
      end
      OP_XP: begin
        a_m = mag(AW'(cur_r));
        b_m = MW'(p_r);
        neg_c = cur_r[STATE_WIDTH-1];
        tag_c = TAG_LOAD;
      end
      OP_OPM: begin
        a_m = mag(AW'(pi_r[cmd.stage]));
        b_m = MW'(p_r);
        neg_c = pi_r[cmd.stage][STATE_WIDTH-1];
        tag_c = TAG_ADD;
      end
      OP_YK: begin
        a_m = mag(AW'(so_r[cmd.stage]));
        b_m = mag(AW'(k_r));
        neg_c = so_r[cmd.stage][STATE_WIDTH-1] ^ k_r[31];
        tag_c = TAG_SUB;
      end
      OP_SQ: begin
        a_m = mag(AW'(cur_r));
        b_m = mag(AW'(cur_r));
        sh_c = SH_X;
        tag_c = TAG_LOAD;
      end
      OP_CU: begin
        a_m = mag(acc_r);
        b_m = mag(AW'(cur_r));
        neg_c = acc_r[AW-1] ^ cur_r[STATE_WIDTH-1];
        sh_c = SH_X;
        tag_c = TAG_LOAD;
      end
      OP_C1: begin
        a_m = MW'(C_0P8);
        b_m = MW'(f_r);
      end
      OP_C2: begin
        a_m = MW'(f_r);
        b_m = MW'(u_r);
      end
      OP_C3: begin
        a_m = MW'(QONE - {1'b0, p_r});
        b_m = MW'(C_T);
      end
      OP_C4: begin
        a_m = MW'(t_r);
        b_m = MW'(t_r);
      end
      OP_C5: begin
        a_m = MW'(res_sat);
        b_m = MW'(scale_r);
        sh_c = SH_16;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PW'(a_m) * PW'(b_m);
      neg_r <= neg_c;
      sh_r <= sh_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= TAG_NONE;
    end else begin
      tag_r <= tag_c;
    end
  end

  // scaled product, sign restored
  always_comb begin
    case (sh_r)
      SH_30:   psh = prod_r >> 30;
      SH_X:    psh = prod_r >> XFRAC;
      SH_16:   psh = prod_r >> 16;
      default: psh = prod_r;
    endcase
    pmag = AW'(psh);
    pval = neg_r ? -pmag : pmag;
  end

  // accumulator
  always_comb begin
    acc_nxt = acc_r;
    case (tag_r)
      TAG_LOAD: acc_nxt = pval;
      TAG_ADD:  acc_nxt = acc_r + pval;
      TAG_SUB:  acc_nxt = acc_r - pval;
      TAG_XSUB: acc_nxt = xconv - pval;
      default:  acc_nxt = acc_r;
    endcase
    if (cmd.op == OP_CLIP) begin
      acc_nxt = AW'(cur_r) - qs;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // divide the cube magnitude by six: reciprocal multiply on the upper
  // chunk, then on the remainder joined with the lower chunk
  always_comb begin
    cu_n = acc_abs[CU_W-1:0];
    qa_prod = 41'(cu_n[CU_W-1:CU_LB]) * 41'(DA_M);
    qa_nxt = 20'(qa_prod >> DA_K);
    ra = 3'(cu_hi_r - 20'({qa_r, 2'b00} + {qa_r, 1'b0}));
    low_nxt = {ra, cu_lo_r};
    ql_prod = (2*CU_LB+6)'(low_r) * (2*CU_LB+6)'(DB_M);
    ql_nxt = CU_LB'(ql_prod >> DB_K);
    cu_q = {qa_r, ql_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= 1'b0;
      d2_r <= 1'b0;
      d3_r <= 1'b0;
    end else begin
      d1_r <= (cmd.op == OP_DIV_CU);
      d2_r <= d1_r;
      d3_r <= d2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_CU) begin
      cu_hi_r <= cu_n[CU_W-1:CU_LB];
      cu_lo_r <= cu_n[CU_LB-1:0];
      qa_r <= qa_nxt;
    end
    if (d1_r) begin
      low_r <= low_nxt;
    end
    if (d2_r) begin
      ql_r <= ql_nxt;
    end
  end

  // divider operands
  always_comb begin
    div_start = 1'b1;
    div_dvd = '0;
    div_dsr = '0;
    div_len = LEN_S;
    case (cmd.op)
      OP_DIV_F: begin
        div_dvd = {cut_r, 1'b0, 30'd0, 7'd0};
        div_dsr = DIV_VW'(rate_r);
        div_len = LEN_F;
      end
      OP_DIV_S: begin
        div_dvd = {num_r[35:10], 30'd0};
        div_dsr = den_r[35:10];
        div_len = LEN_S;
      end
      default: div_start = 1'b0;
    endcase
  end

  lad_div #(
    .DW (DIV_W),
    .VW (DIV_VW),
    .LW (DIV_LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .len      (div_len),
    .done     (div_done),
    .quot     (quot)
  );

  // coefficient registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SET_F: f_r <= f_full ? QONE[30:0] : quot[30:0];
      OP_SET_U: u_r <= C_1P8 - psh[31:0];
      OP_SET_P: p_r <= psh[30:0];
      OP_SET_T: t_r <= psh[31:0];
      OP_SET_N: begin
        num_r <= t2 + six_t;
        den_r <= t2 - six_t;
      end
      OP_SET_S: scale_r <= quot[33:0];
      OP_SET_R: begin
        r_r <= psh[31:0];
        k_r <= 32'({1'b0, p_r, 1'b0} - 33'(QONE));
      end
      default: ;
    endcase
  end

  // ladder state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        so_r[i] <= '0;
        pi_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_STG: begin
          pi_r[cmd.stage] <= cur_r;
          if (cmd.stage != 2'd3) begin
            so_r[cmd.stage] <= y_sat;
          end
        end
        OP_FIN: so_r[3] <= y_sat;
        default: ;
      endcase
    end
  end

  // current stage input, latched word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      samp_r <= in_sample_in;
    end
    if (cmd.op == OP_MX || cmd.op == OP_STG) begin
      cur_r <= y_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      out_r <= ow_sat[SAMPLE_WIDTH-1:0];
    end
  end

  assign stat.div_done = div_done || d3_r;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_r;

endmodule

/* rtl/lad_ctl.sv */
// controller: sequences coefficient and sample micro-programs
module lad_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           cfg_wr_en,
  output lad_pkg::cmd_t  cmd,
  input  lad_pkg::stat_t stat
);
  import lad_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  prog_t pw;
  logic blocked;
  logic [STEP_W-1:0] last;

  // current micro-op and its wait conditions
  always_comb begin
    pw = prog_word(state_r, step_r);
    blocked = ((pw.op == OP_WAIT_DIV) && !stat.div_done) ||
              ((pw.op == OP_FIN) && !stat.out_free);
    last = (state_r == ST_COEF) ? COEF_LAST : RUN_LAST;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    case (state_r)
      ST_COEF, ST_RUN: begin
        if (!blocked) begin
          if (step_r == last) begin
            state_nxt = ST_IDLE;
            step_nxt = '0;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          step_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_COEF;
        step_nxt = '0;
      end
    endcase
    if (cfg_wr_en) begin
      state_nxt = ST_COEF;
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COEF;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

  // outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE) || cfg_wr_en;
    cmd.take = (state_r == ST_IDLE) && in_valid && !cfg_wr_en;
    cmd.op = ((state_r != ST_IDLE) && !blocked) ? pw.op : OP_NOP;
    cmd.stage = pw.stage;
  end

  // an accepted word starts the sample program at its first step
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == ST_RUN) && (step_r == '0))
    else $error("accepted word did not start the sample program");

  // the program holds while the divider is still working
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_IDLE) && (pw.op == OP_WAIT_DIV) && !stat.div_done && !cfg_wr_en)
      |=> $stable(step_r) && $stable(state_r))
    else $error("program advanced before divider finished");

  // a finished result is never dropped by a blocked output
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && (pw.op == OP_FIN) && !stat.out_free) |-> (cmd.op == OP_NOP))
    else $error("result issued while output register is full");

  // coefficient program is recomputed after reset
  a_reset_coef: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (state_r == ST_COEF) && (step_r == '0))
    else $error("reset did not start coefficient recompute");

endmodule

/* rtl/four_pole_ladder_lowpass.sv */
// top level of the four-pole resonant ladder low-pass filter
// Usage:
//   Input words (in_sample_in, signed q1.(SAMPLE_WIDTH-1)) are taken on a
//   clock edge with in_valid high and in_stall low. Each word gives exactly
//   one output word on out_sample_out, handed over on an edge with out_valid
//   high and out_stall low.
//   One word is processed at a time: each sample runs the 31-step sequence
//   around one shared multiplier, in which the clipper term y^3/6 is formed
//   by two reciprocal multiplies.
//   After reset, and after each configuration write, the coefficients are
//   recomputed in 16 steps plus two divisions, during which in_stall stays
//   high. Config regs are written by cfg_wr_en / cfg_index / cfg_wdata
//   (0 cutoff, 1 resonance, 2 sample rate); the user must write them only
//   while the block is idle, which the block itself does not enforce.
//   A finished result waits in the output register while out_stall is high;
//   the block takes the next word meanwhile, and holds that word's result
//   in its last step until the output register frees.
//   rst_n is synchronous and active low; it clears filter state.
module four_pole_ladder_lowpass #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [lad_pkg::CFG_W-1:0]      cfg_wdata
);
  import lad_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  lad_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_wr_en (cfg_wr_en),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic and state
  lad_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

endmodule

/* verif/tb_four_pole_ladder_lowpass.sv */
// self-checking testbench for the four-pole ladder low-pass filter
`timescale 1ns / 1ps

module tb_four_pole_ladder_lowpass;
  import lad_pkg::*;

  localparam int SW = 24;
  localparam int XW = 32;
  localparam int XF = XW - 5;
  localparam int SF = SW - 1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_WORDS = 250;
  localparam int IDLE_LIMIT = 5000;
  localparam int CFG_SETTLE = 200;
  localparam int DRAIN_WAIT = 120;

  typedef struct {
    logic signed [SW-1:0] smp;
    bit                   known;
    logic signed [SW-1:0] want;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_sample_out;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_CUTOFF;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // filter model state
  logic [63:0] m_cutoff, m_reson, m_rate;
  longint m_y[4];
  longint m_xold[4];
  longint m_p, m_k, m_r;

  logic signed [SW-1:0] want_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int idle_cycles = 0;
  int n_settings = 1;
  bit long_done = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;

  drow_t dir_tab[$];

  four_pole_ladder_lowpass u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // exact product of magnitudes, truncated shift, sign restored
  function automatic longint fx_mul(longint a, longint b, int sh);
    logic neg;
    logic [63:0] ua, ub, r;
    logic [127:0] pr;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    pr = {64'd0, ua} * {64'd0, ub};
    r = 64'(pr >> sh);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

  // coefficient update after reset or a register write
  function automatic void update_coefs();
    logic [63:0] f, u, p, t, t2, num, den, scl, res;
    if (m_rate == 0 || 2 * m_cutoff >= m_rate) f = 64'(QONE);
    else f = ((2 * m_cutoff) << 30) / m_rate;
    u = 64'(C_1P8) - ((64'(C_0P8) * f) >> 30);
    p = (f * u) >> 30;
    t = ((64'(QONE) - p) * 64'(C_T)) >> 30;
    t2 = 12 * 64'(QONE) + ((t * t) >> 30);
    num = t2 + 6 * t;
    den = t2 - 6 * t;
    scl = ((num >> 10) << 30) / (den >> 10);
    res = (m_reson > 65536) ? 64'd65536 : m_reson;
    m_p = longint'(p);
    m_k = 2 * longint'(p) - longint'(QONE);
    m_r = longint'((res * scl) >> 16);
  endfunction

  function automatic longint pole(longint x, longint xo, longint yo);
    return clamp(fx_mul(x, m_p, 30) + fx_mul(xo, m_p, 30) - fx_mul(yo, m_k, 30), XW);
  endfunction

  // one sample through the ladder, updates the state
  function automatic logic signed [SW-1:0] ladder_step(logic signed [SW-1:0] smp);
    longint x, mx, y1, y2, y3, y4, sq, cu, o;
    x = longint'(smp) * (longint'(1) <<< (XF - SF));
    mx = clamp(x - fx_mul(m_y[3], m_r, 30), XW);
    y1 = pole(mx, m_xold[0], m_y[0]);
    y2 = pole(y1, m_xold[1], m_y[1]);
    y3 = pole(y2, m_xold[2], m_y[2]);
    y4 = pole(y3, m_xold[3], m_y[3]);
    sq = fx_mul(y4, y4, XF);
    cu = fx_mul(sq, y4, XF);
    y4 = clamp(y4 - cu / 6, XW);
    m_y[0] = y1; m_y[1] = y2; m_y[2] = y3; m_y[3] = y4;
    m_xold[0] = mx; m_xold[1] = y1; m_xold[2] = y2; m_xold[3] = y3;
    o = clamp(y4 >>> (XF - SF), SW);
    return SW'(o);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d (word %0d)", what, got, want, n_recv);
    errors++;
  endtask

  // one register write, then let the coefficient pass finish
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_CUTOFF: begin m_cutoff = 64'(val); update_coefs(); end
      CFG_RESON:  begin m_reson = 64'(val[16:0]); update_coefs(); end
      CFG_RATE:   begin m_rate = 64'(val); update_coefs(); end
      default: ;
    endcase
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic set_all(int unsigned co, int unsigned rs, int unsigned rt);
    write_reg(CFG_CUTOFF, CFG_W'(co));
    write_reg(CFG_RESON, CFG_W'(rs));
    write_reg(CFG_RATE, CFG_W'(rt));
    n_settings++;
  endtask

  // offer one word and hold it until taken
  task automatic send_word(logic signed [SW-1:0] v, bit known, logic signed [SW-1:0] want);
    logic signed [SW-1:0] pred;
    in_valid <= 1'b1;
    in_sample_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = ladder_step(v);
    want_q.push_back(known ? want : pred);
    n_sent++;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      1, 2: return SW'($signed($urandom_range(0, 8191)) - 4096);
      3: return SW'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return SW'($urandom());
    endcase
  endfunction

  // bursts of random length with random gaps
  task automatic send_random(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
      send_word(rand_sample(), 1'b0, '0);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          report_mismatch("unexpected word", out_sample_out, 0);
        end else begin
          if (out_sample_out !== want_q[0])
            report_mismatch("sample_out", out_sample_out, want_q[0]);
          void'(want_q.pop_front());
        end
        n_recv++;
      end
      if (!long_done && n_sent >= 400) begin
        long_done <= 1'b1;
        hold_left <= 600;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", want_q.size());
      $display("four_pole_ladder_lowpass verification failed");
      $finish;
    end
  end

  initial begin
    m_cutoff = 48000;
    m_reson = 0;
    m_rate = 48000;
    for (int i = 0; i < 4; i++) begin
      m_y[i] = 0;
      m_xold[i] = 0;
    end
    update_coefs();

    // zero in from a cleared state gives zero out
    dir_tab.push_back('{24'sd0, 1'b1, 24'sd0});
    dir_tab.push_back('{24'sh7FFFFF, 1'b0, '0});
    dir_tab.push_back('{24'sh7FFFFF, 1'b0, '0});
    dir_tab.push_back('{24'sh800000, 1'b0, '0});
    dir_tab.push_back('{24'sh800000, 1'b0, '0});
    dir_tab.push_back('{24'sh7FFFFF, 1'b0, '0});
    dir_tab.push_back('{24'sd1, 1'b0, '0});
    dir_tab.push_back('{-24'sd1, 1'b0, '0});
    dir_tab.push_back('{24'sh555555, 1'b0, '0});
    dir_tab.push_back('{24'shAAAAAA, 1'b0, '0});
    dir_tab.push_back('{24'sd0, 1'b0, '0});
    dir_tab.push_back('{24'sd0, 1'b0, '0});
    dir_tab.push_back('{24'sh400000, 1'b0, '0});
    dir_tab.push_back('{-24'sh400000, 1'b0, '0});
    dir_tab.push_back('{24'sh7FFFFF, 1'b0, '0});
    dir_tab.push_back('{24'sh7FFFFF, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (CFG_SETTLE) @(posedge clk);

    // reset settings: directed table then random words
    foreach (dir_tab[i]) send_word(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].want);
    send_random(PHASE_WORDS - dir_tab.size());
    drain();

    // lowest settings
    set_all(0, 0, 8000);
    send_random(PHASE_WORDS);
    drain();

    // highest settings, full resonance
    set_all(192000, 65536, 192000);
    send_random(PHASE_WORDS);
    drain();

    // resonance over range saturates, zero rate
    set_all(1000, 131071, 0);
    send_random(PHASE_WORDS);
    drain();

    // all-ones data, unused register index, typical rate
    set_all(262143, 262143, 44100);
    write_reg(CFG_UNUSED, 18'h15555);
    send_random(PHASE_WORDS);
    drain();

    // a few random musical settings
    for (int ph = 0; ph < 3; ph++) begin
      int unsigned rt;
      rt = $urandom_range(8000, 192000);
      set_all($urandom_range(20, rt / 2), $urandom_range(0, 65536), rt);
      send_random(PHASE_WORDS / 3);
      drain();
    end

    $display("ran %0d samples through %0d coefficient settings, %0d words checked",
             n_sent, n_settings, n_recv);
    $display("included saturated input, overdriven resonance and a long output hold-off");
    if (errors == 0 && want_q.size() == 0) begin
      $display("four_pole_ladder_lowpass verification clean");
    end else begin
      $display("%0d mismatches, %0d words never arrived", errors, want_q.size());
      $display("four_pole_ladder_lowpass verification failed");
    end
    $finish;
  end

endmodule
